/* design/asws_pkg.sv */
// Shared types, constants and the quarter-wave sine generator for the
// additive sine-wave synthesiser. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package asws_pkg;

    // Fixed widths of the register fields, the datapath and the sample, and the slot count
    localparam int unsigned WAVE_SLOTS = 4;
    localparam int unsigned AMP_W     = 8;
    localparam int unsigned PHASE_W   = 16;
    localparam int unsigned TAB_W     = 15;             // Q14 magnitude, 0..16384
    localparam int unsigned MAG_W     = AMP_W + TAB_W;  // one product
    localparam int unsigned ACC_W     = 25;             // sum of four signed products
    localparam int unsigned Y_W       = 15;
    localparam int unsigned ADDR_W    = 5;              // eight 32-bit registers
    localparam int unsigned DATA_W    = 32;

    // Default parameter values
    localparam int unsigned WAVE_COUNT       = 4;
    localparam int unsigned SINE_TABLE_DEPTH = 256;

    // Phase constants (65536 counts per turn)
    localparam logic [PHASE_W-1:0] FRAME_ADVANCE = 16'd209;   // 0.02 rad
    localparam logic [PHASE_W-1:0] QUARTER_TURN  = 16'd16384;
    localparam logic [63:0]        HALF_PI_Q30   = 64'd1686629713;

    // Output scaling: Q14 pixels down to Q4 with round half up
    localparam logic signed [ACC_W-1:0] ROUND_HALF = 25'sd512;
    localparam int unsigned             FRAC_SHIFT = 10;
    localparam logic signed [ACC_W-1:0] Y_MIN      = -25'sd16384;
    localparam logic signed [ACC_W-1:0] Y_MAX      = 25'sd16383;

    // Register reset values
    localparam logic [AMP_W-1:0]   AMP_RESET  = 8'd20;
    localparam logic [PHASE_W-1:0] STEP_RESET = 16'd2621;

    // Register map, one word per register
    typedef enum logic [2:0] {
        REG_AMP_WAVE0  = 3'd0,
        REG_AMP_WAVE1  = 3'd1,
        REG_AMP_WAVE2  = 3'd2,
        REG_AMP_WAVE3  = 3'd3,
        REG_STEP_WAVE0 = 3'd4,
        REG_STEP_WAVE1 = 3'd5,
        REG_STEP_WAVE2 = 3'd6,
        REG_STEP_WAVE3 = 3'd7
    } reg_idx_t;

    // Configuration handed from the register block to the cells
    typedef struct packed {
        logic [WAVE_SLOTS-1:0][AMP_W-1:0]   amp;
        logic [WAVE_SLOTS-1:0][PHASE_W-1:0] step;
    } cfg_t;

    // What one transfer carries from cell to cell
    typedef struct packed {
        logic                     valid;
        logic                     new_frame;
        logic [PHASE_W-1:0]       base;
        logic signed [ACC_W-1:0]  psum;
    } link_t;

    // Taylor divisors (2n)(2n+1) for n = 1..7
    localparam logic [63:0] TAYLOR_DIV [7] = '{64'd6, 64'd20, 64'd42, 64'd72,
                                               64'd110, 64'd156, 64'd210};

    // Q14 sine of an angle given in Q30 radians, evaluated at elaboration
    function automatic logic [TAB_W-1:0] sine_q14_from_x(input logic [63:0] x);
        logic [63:0] x2;
        logic [63:0] term;
        logic [63:0] pos;
        logic [63:0] neg;
        logic [63:0] s;
        int          n;
        x2   = (x * x) >> 30;
        term = x;
        pos  = x;
        neg  = '0;
        for (n = 1; n <= 7; n++) begin
            term = (term * x2) >> 30;
            term = term / TAYLOR_DIV[n-1];
            if ((n & 1) != 0)
                neg = neg + term;
            else
                pos = pos + term;
        end
        s = (pos > neg) ? (pos - neg) : 64'd0;
        s = (s + 64'd32768) >> 16;
        if (s > 64'd16384)
            s = 64'd16384;
        return s[TAB_W-1:0];
    endfunction

endpackage

`default_nettype wire

/* design/asws_cfg.sv */
// APB-style register block: amplitudes and phase steps of the four waves.
// Depends on asws_pkg.
`timescale 1ns / 1ps
`default_nettype none

module asws_cfg
(
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [asws_pkg::ADDR_W-1:0]   paddr,
    input  wire logic [asws_pkg::DATA_W-1:0]   pwdata,
    output logic      [asws_pkg::DATA_W-1:0]   prdata,
    output logic                               pready,
    output asws_pkg::cfg_t                     cfg
);

    logic [asws_pkg::WAVE_SLOTS-1:0][asws_pkg::AMP_W-1:0]   amp_reg;
    logic [asws_pkg::WAVE_SLOTS-1:0][asws_pkg::PHASE_W-1:0] step_reg;
    asws_pkg::reg_idx_t                                     idx;
    logic                                                   wr_en;

    assign pready = 1'b1;
    assign idx    = asws_pkg::reg_idx_t'(paddr[asws_pkg::ADDR_W-1:2]);
    assign wr_en  = psel && penable && pwrite;

    // Register writes on the access phase
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < asws_pkg::WAVE_SLOTS; i++)
            begin
                amp_reg[i]  <= asws_pkg::AMP_RESET;
                step_reg[i] <= asws_pkg::STEP_RESET;
            end
        end
        else if (wr_en)
        begin
            case (idx)
                asws_pkg::REG_AMP_WAVE0:  amp_reg[0]  <= pwdata[asws_pkg::AMP_W-1:0];
                asws_pkg::REG_AMP_WAVE1:  amp_reg[1]  <= pwdata[asws_pkg::AMP_W-1:0];
                asws_pkg::REG_AMP_WAVE2:  amp_reg[2]  <= pwdata[asws_pkg::AMP_W-1:0];
                asws_pkg::REG_AMP_WAVE3:  amp_reg[3]  <= pwdata[asws_pkg::AMP_W-1:0];
                asws_pkg::REG_STEP_WAVE0: step_reg[0] <= pwdata[asws_pkg::PHASE_W-1:0];
                asws_pkg::REG_STEP_WAVE1: step_reg[1] <= pwdata[asws_pkg::PHASE_W-1:0];
                asws_pkg::REG_STEP_WAVE2: step_reg[2] <= pwdata[asws_pkg::PHASE_W-1:0];
                asws_pkg::REG_STEP_WAVE3: step_reg[3] <= pwdata[asws_pkg::PHASE_W-1:0];
                default: ;
            endcase
        end
    end

    // Read-back mux
    always_comb
    begin
        case (idx)
            asws_pkg::REG_AMP_WAVE0:  prdata = asws_pkg::DATA_W'(amp_reg[0]);
            asws_pkg::REG_AMP_WAVE1:  prdata = asws_pkg::DATA_W'(amp_reg[1]);
            asws_pkg::REG_AMP_WAVE2:  prdata = asws_pkg::DATA_W'(amp_reg[2]);
            asws_pkg::REG_AMP_WAVE3:  prdata = asws_pkg::DATA_W'(amp_reg[3]);
            asws_pkg::REG_STEP_WAVE0: prdata = asws_pkg::DATA_W'(step_reg[0]);
            asws_pkg::REG_STEP_WAVE1: prdata = asws_pkg::DATA_W'(step_reg[1]);
            asws_pkg::REG_STEP_WAVE2: prdata = asws_pkg::DATA_W'(step_reg[2]);
            asws_pkg::REG_STEP_WAVE3: prdata = asws_pkg::DATA_W'(step_reg[3]);
            default:                  prdata = '0;
        endcase
    end

    assign cfg.amp  = amp_reg;
    assign cfg.step = step_reg;

endmodule

`default_nettype wire

/* design/asws_cell.sv */
// One wave of the chain: phase accumulator, quarter-wave table and a
// multiply-add onto the running sum. Depends on asws_pkg.
`timescale 1ns / 1ps
`default_nettype none

module asws_cell
#(
    parameter int unsigned WAVE_IDX = 0,
    parameter int unsigned DEPTH    = asws_pkg::SINE_TABLE_DEPTH
)
(
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic [asws_pkg::AMP_W-1:0]     amp,
    input  wire logic [asws_pkg::PHASE_W-1:0]   step,
    input  wire asws_pkg::link_t                link_in,
    output logic                                ready_out,
    output asws_pkg::link_t                     link_out,
    input  wire logic                           ready_in
);

    localparam int unsigned IDX_W  = $clog2(DEPTH + 1);
    localparam int unsigned OFF_W  = asws_pkg::PHASE_W - 2;
    localparam int unsigned PROD_W = OFF_W + IDX_W;
    localparam bit          IS_COS = (WAVE_IDX % 2) == 1;

    // Quarter-wave table, built at elaboration
    logic [asws_pkg::TAB_W-1:0] rom [0:DEPTH];

    for (genvar k = 0; k <= DEPTH; k++)
    begin : g_rom
        localparam logic [63:0] X =
            (64'(k) * asws_pkg::HALF_PI_Q30 + 64'(DEPTH / 2)) / 64'(DEPTH);
        localparam logic [asws_pkg::TAB_W-1:0] V = asws_pkg::sine_q14_from_x(X);
        assign rom[k] = V;
    end

    logic [asws_pkg::PHASE_W-1:0]   phase_reg;
    logic [asws_pkg::PHASE_W-1:0]   phase_use;
    logic [asws_pkg::PHASE_W-1:0]   look_phase;
    logic [PROD_W-1:0]              idx_prod;
    logic [IDX_W-1:0]               idx;
    logic [IDX_W-1:0]               addr_next;

    // Stage A: table address
    logic                           a_valid_reg;
    logic                           a_nf_reg;
    logic [asws_pkg::PHASE_W-1:0]   a_base_reg;
    logic signed [asws_pkg::ACC_W-1:0] a_psum_reg;
    logic [IDX_W-1:0]               a_addr_reg;
    logic                           a_neg_reg;

    // Stage T: table data
    logic                           t_valid_reg;
    logic                           t_nf_reg;
    logic [asws_pkg::PHASE_W-1:0]   t_base_reg;
    logic signed [asws_pkg::ACC_W-1:0] t_psum_reg;
    logic [asws_pkg::TAB_W-1:0]     t_tab_reg;
    logic                           t_neg_reg;

    // Stage C: sum out
    logic                           c_valid_reg;
    logic                           c_nf_reg;
    logic [asws_pkg::PHASE_W-1:0]   c_base_reg;
    logic signed [asws_pkg::ACC_W-1:0] c_psum_reg;
    logic [asws_pkg::MAG_W-1:0]     mag;
    logic signed [asws_pkg::ACC_W-1:0] psum_next;

    logic en_a;
    logic en_t;
    logic en_c;
    logic take;

    // Each stage moves when it is empty or the next one moves
    assign en_c      = !c_valid_reg || ready_in;
    assign en_t      = !t_valid_reg || en_c;
    assign en_a      = !a_valid_reg || en_t;
    assign ready_out = en_a;
    assign take      = link_in.valid && en_a;

    // Phase used by this item; a new frame restarts from the base phase
    assign phase_use  = link_in.new_frame ? link_in.base : phase_reg;
    assign look_phase = phase_use + (IS_COS ? asws_pkg::QUARTER_TURN : '0);
    assign idx_prod   = PROD_W'(look_phase[OFF_W-1:0]) * PROD_W'(DEPTH);
    assign idx        = idx_prod[PROD_W-1:OFF_W];
    // Odd quadrants read the table mirrored
    assign addr_next  = look_phase[asws_pkg::PHASE_W-2] ? (IDX_W'(DEPTH) - idx) : idx;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            phase_reg <= '0;
        else if (take)
            phase_reg <= phase_use + step;
    end

    // Valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            t_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
        end
        else
        begin
            if (en_a)
                a_valid_reg <= link_in.valid;
            if (en_t)
                t_valid_reg <= a_valid_reg;
            if (en_c)
                c_valid_reg <= t_valid_reg;
        end
    end

    // Payload
    always_ff @(posedge clk)
    begin
        if (en_a)
        begin
            a_nf_reg   <= link_in.new_frame;
            a_base_reg <= link_in.base;
            a_psum_reg <= link_in.psum;
            a_addr_reg <= addr_next;
            a_neg_reg  <= look_phase[asws_pkg::PHASE_W-1];
        end
        if (en_t)
        begin
            t_nf_reg   <= a_nf_reg;
            t_base_reg <= a_base_reg;
            t_psum_reg <= a_psum_reg;
            t_tab_reg  <= rom[a_addr_reg];
            t_neg_reg  <= a_neg_reg;
        end
        if (en_c)
        begin
            c_nf_reg   <= t_nf_reg;
            c_base_reg <= t_base_reg;
            c_psum_reg <= psum_next;
        end
    end

    // Multiply-add onto the running sum
    assign mag       = asws_pkg::MAG_W'(amp) * asws_pkg::MAG_W'(t_tab_reg);
    assign psum_next = t_neg_reg ? (t_psum_reg - $signed(asws_pkg::ACC_W'(mag)))
                                 : (t_psum_reg + $signed(asws_pkg::ACC_W'(mag)));

    assign link_out = '{valid: c_valid_reg, new_frame: c_nf_reg,
                        base: c_base_reg, psum: c_psum_reg};

endmodule

`default_nettype wire

/* design/additive_sine_wave_synth_top.sv */
// Top level of the additive sine-wave synthesiser: register block, chain of
// wave cells and the output register. Depends on asws_pkg, asws_cfg, asws_cell.
`timescale 1ns / 1ps
`default_nettype none

// Usage
//   Input channel item_valid / item_stall carries new_frame: 1 starts a new
//   frame (base phase moves on by 209 counts and every wave restarts from it),
//   0 moves to the next column. Each transfer gives one sample on the output
//   channel sample_valid / sample_stall as y_value, signed Q4, saturated.
//   Registers amp_wave0..3 and step_wave0..3 sit at byte addresses 0..28 of
//   the APB port; write them only while the block is empty.
//   Path: the item passes 3 * WAVE_COUNT + 1 registers (three stages per
//   wave cell plus the output register) on its way to y_value.
//   Throughput: one item per cycle while the output is not stalled, set by
//   each cell's phase accumulator, which updates once per item.
//   A stalled output holds its sample; the chain keeps taking items until
//   every stage is full, then item_stall rises.
//   Reset clears all phases and valid bits and loads the register defaults
//   (amplitude 20, step 2621); the block accepts items straight after reset.

module additive_sine_wave_synth_top
#(
    parameter int unsigned WAVE_COUNT       = asws_pkg::WAVE_COUNT,
    parameter int unsigned SINE_TABLE_DEPTH = asws_pkg::SINE_TABLE_DEPTH
)
(
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                psel,
    input  wire logic                                penable,
    input  wire logic                                pwrite,
    input  wire logic [asws_pkg::ADDR_W-1:0]         paddr,
    input  wire logic [asws_pkg::DATA_W-1:0]         pwdata,
    output logic      [asws_pkg::DATA_W-1:0]         prdata,
    output logic                                     pready,
    input  wire logic                                item_valid,
    output logic                                     item_stall,
    input  wire logic                                new_frame,
    output logic                                     sample_valid,
    input  wire logic                                sample_stall,
    output logic signed [asws_pkg::Y_W-1:0]          y_value
);

    asws_pkg::cfg_t                     cfg;
    asws_pkg::link_t                    link [WAVE_COUNT+1];
    logic [WAVE_COUNT:0]                ready;
    logic [asws_pkg::PHASE_W-1:0]       base_reg;
    logic [asws_pkg::PHASE_W-1:0]       base_next;
    logic                               in_take;
    logic                               out_en;
    logic                               sample_valid_reg;
    logic signed [asws_pkg::Y_W-1:0]    y_reg;
    logic signed [asws_pkg::ACC_W-1:0]  rounded;
    logic signed [asws_pkg::ACC_W-1:0]  y_full;
    logic signed [asws_pkg::Y_W-1:0]    y_sat;

    asws_cfg u_cfg
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // Head: base phase and entry into the chain
    assign base_next  = base_reg + asws_pkg::FRAME_ADVANCE;
    assign item_stall = !ready[0];
    assign in_take    = item_valid && ready[0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            base_reg <= '0;
        else if (in_take && new_frame)
            base_reg <= base_next;
    end

    assign link[0].valid     = item_valid;
    assign link[0].new_frame = new_frame;
    assign link[0].base      = new_frame ? base_next : base_reg;
    assign link[0].psum      = '0;

    // Chain of wave cells
    for (genvar j = 0; j < WAVE_COUNT; j++)
    begin : g_cell
        asws_cell
        #(
            .WAVE_IDX (j),
            .DEPTH    (SINE_TABLE_DEPTH)
        )
        u_cell
        (
            .clk       (clk),
            .rst_n     (rst_n),
            .amp       (cfg.amp[j]),
            .step      (cfg.step[j]),
            .link_in   (link[j]),
            .ready_out (ready[j]),
            .link_out  (link[j+1]),
            .ready_in  (ready[j+1])
        );
    end

    // Tail: round to Q4 and saturate
    assign rounded = link[WAVE_COUNT].psum + asws_pkg::ROUND_HALF;
    assign y_full  = rounded >>> asws_pkg::FRAC_SHIFT;

    always_comb
    begin
        if (y_full < asws_pkg::Y_MIN)
            y_sat = asws_pkg::Y_MIN[asws_pkg::Y_W-1:0];
        else if (y_full > asws_pkg::Y_MAX)
            y_sat = asws_pkg::Y_MAX[asws_pkg::Y_W-1:0];
        else
            y_sat = y_full[asws_pkg::Y_W-1:0];
    end

    // Output register
    assign out_en            = !sample_valid_reg || !sample_stall;
    assign ready[WAVE_COUNT] = out_en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            sample_valid_reg <= 1'b0;
        else if (out_en)
            sample_valid_reg <= link[WAVE_COUNT].valid;
    end

    always_ff @(posedge clk)
    begin
        if (out_en)
            y_reg <= y_sat;
    end

    assign sample_valid = sample_valid_reg;
    assign y_value      = y_reg;

endmodule

`default_nettype wire

/* design/asws_checker.sv */
// Port-level checks for the additive sine-wave synthesiser, bound to the
// top level. Depends on asws_pkg and additive_sine_wave_synth_top.
`timescale 1ns / 1ps
`default_nettype none

module asws_checker
#(
    parameter int unsigned WAVE_COUNT = asws_pkg::WAVE_COUNT
)
(
    input wire logic                               clk,
    input wire logic                               rst_n,
    input wire logic                               pready,
    input wire logic                               item_valid,
    input wire logic                               item_stall,
    input wire logic                               sample_valid,
    input wire logic                               sample_stall,
    input wire logic signed [asws_pkg::Y_W-1:0]    y_value
);

    // Items the block can hold: three per cell and the output register
    localparam int unsigned CAP   = 3 * WAVE_COUNT + 1;
    localparam int unsigned CNT_W = $clog2(CAP + 2);

    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             in_xfer;
    logic             out_xfer;

    assign in_xfer  = item_valid && !item_stall;
    assign out_xfer = sample_valid && !sample_stall;

    always_comb
    begin
        count_next = count_reg;
        if (in_xfer && !out_xfer)
            count_next = count_reg + 1'b1;
        else if (!in_xfer && out_xfer)
            count_next = count_reg - 1'b1;
    end

    // Items taken but not yet delivered
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            count_reg <= '0;
        else
            count_reg <= count_next;
    end

    // A stalled sample holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (sample_valid && sample_stall) |=> (sample_valid && $stable(y_value)))
        else $error("stalled sample changed");

    // Input is only stalled when the output is backed up
    a_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
        item_stall |-> (sample_valid && sample_stall && pready))
        else $error("input stalled without output back-pressure");

    // No sample without an item in flight
    a_no_invent: assert property (@(posedge clk) disable iff (!rst_n)
        sample_valid |-> (count_reg != '0))
        else $error("sample offered with no item outstanding");

    // Never more items inside than the chain can hold
    a_capacity: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(CAP))
        else $error("more items held than pipeline stages");

endmodule

bind additive_sine_wave_synth_top asws_checker #(.WAVE_COUNT(WAVE_COUNT)) u_asws_checker
(
    .clk          (clk),
    .rst_n        (rst_n),
    .pready       (pready),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .sample_valid (sample_valid),
    .sample_stall (sample_stall),
    .y_value      (y_value)
);

`default_nettype wire
